/* hw/rtl/epdps_pkg.sv */
// Shared types and constants for the edge-disjoint probe path selector.
// Used by the pair index unit and the top level; depends on nothing else.
package epdps_pkg;

	localparam int NODE_COUNT = 64;
	localparam int NODE_W     = 6;
	localparam int MARK_W     = 8;
	localparam int MARK_DEPTH = NODE_COUNT * NODE_COUNT;
	localparam int ADDR_W     = $clog2(MARK_DEPTH);
	localparam int TOTAL_W    = 20;
	localparam int OP_W       = 2;
	localparam int LEN_W      = 2;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// One unordered node pair as seen by the store.
	typedef struct packed {
		logic              ok;        // both nodes are below NODE_COUNT
		logic              self_loop; // both ends name the same node
		logic [ADDR_W-1:0] idx;       // smaller * NODE_COUNT + larger
	} pair_t;

endpackage

/* hw/rtl/epdps_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined until written.
module epdps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

/* hw/rtl/epdps_pair.sv */
// Pair index unit: orders two nodes of the held path and forms the store index.
// Used by the read steps of the sequencer to address the store; uses epdps_pkg.
module epdps_pair (
	input  logic                           second_edge,
	input  logic [epdps_pkg::NODE_W-1:0]   node_first,
	input  logic [epdps_pkg::NODE_W-1:0]   node_second,
	input  logic [epdps_pkg::NODE_W-1:0]   node_third,
	output epdps_pkg::pair_t               pair
);
	import epdps_pkg::*;

	logic [NODE_W-1:0] a;
	logic [NODE_W-1:0] b;
	logic [NODE_W-1:0] lo;
	logic [NODE_W-1:0] hi;

	always_comb begin
		a  = second_edge ? node_second : node_first;
		b  = second_edge ? node_third  : node_second;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		pair.ok        = ({1'b0, hi} < (NODE_W+1)'(NODE_COUNT));
		pair.self_loop = (a == b);
		pair.idx       = ADDR_W'(lo) * ADDR_W'(NODE_COUNT) + ADDR_W'(hi);
	end

endmodule

/* hw/rtl/edge_disjoint_probe_path_selector.sv */
// Edge-disjoint probe path selector: sequencer, mark store and totals.
// An offered path holds the block for one store read per edge and, if it is taken, one write
// per edge on the single store port; a query reads one entry; a clear zeroes every entry, one entry a cycle.
// The result is registered in the output register after the last step; the next item can be
// taken while it waits. After reset tready stays low for a clearing pass over the store,
// and both totals start at zero.
module edge_disjoint_probe_path_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// node_first[5:0], node_second[11:6], node_third[17:12], path_length[19:18], zero
	input  logic [epdps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// op[1:0]
	input  logic [epdps_pkg::OP_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// selected[0], edge_count[8:1], selected_paths[28:9], rejected_paths[48:29], zero
	output logic [epdps_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import epdps_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD0  = 4'd1;
	localparam logic [3:0] S_RD1  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_WR0  = 4'd4;
	localparam logic [3:0] S_WR1  = 4'd5;
	localparam logic [3:0] S_QRD  = 4'd6;
	localparam logic [3:0] S_QWT  = 4'd7;
	localparam logic [3:0] S_CLR  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]          state_q;
	logic                boot_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                hit_q;
	logic                rd_pend_q;
	logic [TOTAL_W-1:0]  sel_total_q;
	logic [TOTAL_W-1:0]  rej_total_q;

	logic [NODE_W-1:0]   n0_q, n1_q, n2_q;
	logic [1:0]          edges_q;
	logic [OP_W-1:0]     op_in;
	logic [LEN_W-1:0]    len_in;
	logic [1:0]          edges_in;
	logic [ADDR_W-1:0]   idx0_q, idx1_q;
	logic [1:0]          amt0_q, amt1_q;
	logic                sel_q;
	logic [MARK_W-1:0]   cnt_q;

	logic                m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	pair_t               pair;
	logic                mem_en, mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [MARK_W-1:0]   mem_wdata, mem_rdata;
	logic                rd_hit, final_hit, same_pair, accept, out_load;
	logic [2:0]          amt_sum;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op_in         = s_axis_tuser;
	assign len_in        = s_axis_tdata[19:18];
	assign edges_in      = (len_in == 2'd0) ? 2'd0 : len_in - 2'd1;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	epdps_pair u_pair (
		.second_edge (state_q == S_RD1),
		.node_first  (n0_q),
		.node_second (n1_q),
		.node_third  (n2_q),
		.pair        (pair)
	);

	epdps_ram #(
		.WIDTH (MARK_W),
		.DEPTH (MARK_DEPTH)
	) u_marks (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign rd_hit    = rd_pend_q && (mem_rdata != '0);
	assign final_hit = hit_q || rd_hit;
	assign same_pair = (edges_q == 2'd2) && (idx0_q == idx1_q);
	assign amt_sum   = {1'b0, amt0_q} + {1'b0, amt1_q};

	// A taken path had only zero counts, so each write is just the amount added.
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pair.idx;
		mem_wdata = '0;
		unique case (state_q)
			S_RD0, S_RD1, S_QRD: begin
				mem_en = 1'b1;
			end
			S_WR0: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = idx0_q;
				mem_wdata = same_pair ? MARK_W'(amt_sum) : MARK_W'(amt0_q);
			end
			S_WR1: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = idx1_q;
				mem_wdata = same_pair ? MARK_W'(amt_sum) : MARK_W'(amt1_q);
			end
			S_CLR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			boot_q      <= 1'b1;
			clr_addr_q  <= '0;
			hit_q       <= 1'b0;
			rd_pend_q   <= 1'b0;
			sel_total_q <= '0;
			rej_total_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == S_RD0) || (state_q == S_RD1) || (state_q == S_QRD);
			if (rd_hit) begin
				hit_q <= 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						if (op_in == OP_OFFER) begin
							state_q <= (edges_in == 2'd0) ? S_CHK : S_RD0;
						end else if (op_in == OP_QUERY) begin
							state_q <= S_QRD;
						end else if (op_in == OP_CLEAR) begin
							state_q    <= S_CLR;
							boot_q     <= 1'b0;
							clr_addr_q <= '0;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_RD0: begin
					if (!pair.ok) begin
						hit_q <= 1'b1;
					end
					state_q <= (edges_q == 2'd2) ? S_RD1 : S_CHK;
				end
				S_RD1: begin
					if (!pair.ok) begin
						hit_q <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (final_hit) begin
						if (rej_total_q != TOTAL_MAX) begin
							rej_total_q <= rej_total_q + TOTAL_W'(1);
						end
						state_q <= S_OUT;
					end else begin
						if (sel_total_q != TOTAL_MAX) begin
							sel_total_q <= sel_total_q + TOTAL_W'(1);
						end
						state_q <= (edges_q == 2'd0) ? S_OUT : S_WR0;
					end
				end
				S_WR0: begin
					state_q <= (edges_q == 2'd2) ? S_WR1 : S_OUT;
				end
				S_WR1: begin
					state_q <= S_OUT;
				end
				S_QRD: begin
					if (!pair.ok) begin
						hit_q <= 1'b1;
					end
					state_q <= S_QWT;
				end
				S_QWT: begin
					state_q <= S_OUT;
				end
				S_CLR: begin
					sel_total_q <= '0;
					rej_total_q <= '0;
					clr_addr_q  <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(MARK_DEPTH - 1)) begin
						state_q <= boot_q ? S_IDLE : S_OUT;
						boot_q  <= 1'b0;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and per-item results.
	always_ff @(posedge clk) begin
		if (accept) begin
			n0_q    <= s_axis_tdata[5:0];
			n1_q    <= s_axis_tdata[11:6];
			n2_q    <= s_axis_tdata[17:12];
			edges_q <= edges_in;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
		end
		if (state_q == S_RD0) begin
			idx0_q <= pair.idx;
			amt0_q <= pair.self_loop ? 2'd2 : 2'd1;
		end
		if (state_q == S_RD1) begin
			idx1_q <= pair.idx;
			amt1_q <= pair.self_loop ? 2'd2 : 2'd1;
		end
		if ((state_q == S_CHK) && !final_hit) begin
			sel_q <= 1'b1;
		end
		if (state_q == S_QWT) begin
			cnt_q <= hit_q ? '0 : mem_rdata;
		end
		if (out_load) begin
			m_data_q <= {7'd0, rej_total_q, sel_total_q, cnt_q, sel_q};
		end
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_WR0 || state_q == S_WR1 || state_q == S_CLR))
		else $error("mark store written outside a write or clear step");

	a_one_total: assert property (@(posedge clk) disable iff (!arst_n)
		!((sel_total_q != $past(sel_total_q)) && (rej_total_q != $past(rej_total_q))
		  && ($past(state_q) != S_CLR)))
		else $error("both totals changed for one item");

	a_sel_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLR) |=> (sel_total_q == $past(sel_total_q)
			|| sel_total_q == $past(sel_total_q) + TOTAL_W'(1)))
		else $error("selected total moved by more than one");

	a_write_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR0) |-> !hit_q)
		else $error("path written although an edge was marked");

	a_load_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !m_valid_q) |=> m_valid_q)
		else $error("result not loaded into a free output register");

endmodule

/* test/path_selector_checker.sv */
// Checker for the edge-disjoint probe path selector: tracks the mark store and
// the path totals from the items the block accepts, and compares every result.
// Depends on epdps_pkg for widths and op codes.
`timescale 1ns / 100ps

module path_selector_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [epdps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [epdps_pkg::OP_W-1:0]       s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [epdps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                               fail_count,
	output int                               pending_count
);
	import epdps_pkg::*;

	typedef struct packed {
		logic               selected;
		logic [MARK_W-1:0]  edge_count;
		logic [TOTAL_W-1:0] selected_paths;
		logic [TOTAL_W-1:0] rejected_paths;
	} outcome_t;

	logic [MARK_W-1:0]  marks [MARK_DEPTH];
	logic [TOTAL_W-1:0] taken_total;
	logic [TOTAL_W-1:0] refused_total;
	outcome_t           expected_outcomes [$];
	int                 mismatches;

	// Store slot of an unordered pair; returns 0 when a node lies outside the graph.
	function automatic logic pair_slot(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
		output int unsigned slot);
		int unsigned lo;
		int unsigned hi;
		lo = 32'((a < b) ? a : b);
		hi = 32'((a < b) ? b : a);
		slot = lo * NODE_COUNT + hi;
		return hi < NODE_COUNT;
	endfunction

	function automatic outcome_t apply_probe_item(input logic [OP_W-1:0] op,
		input logic [IN_DATA_W-1:0] data);
		logic [NODE_W-1:0] node [3];
		int unsigned       len;
		int unsigned       slot [2];
		int unsigned       sum;
		logic              path_free;
		outcome_t          res;
		node[0] = data[5:0];
		node[1] = data[11:6];
		node[2] = data[17:12];
		len = 32'(data[19:18]);
		if (len == 0)
			len = 1;
		res = '0;
		case (op)
		OP_OFFER: begin
			// Every edge is checked before any count moves, so a path that names the
			// same pair twice is judged on the pair's old count.
			path_free = 1'b1;
			for (int e = 0; e < len - 1; e++) begin
				if (!pair_slot(node[e], node[e + 1], slot[e]))
					path_free = 1'b0;
				else if (marks[slot[e]] != 0)
					path_free = 1'b0;
			end
			if (path_free) begin
				for (int e = 0; e < len - 1; e++) begin
					// A self loop hits the shared entry from both directions.
					sum = 32'(marks[slot[e]]) + ((node[e] == node[e + 1]) ? 32'd2 : 32'd1);
					marks[slot[e]] = (sum > 255) ? 8'd255 : sum[MARK_W-1:0];
				end
				if (taken_total != TOTAL_MAX)
					taken_total++;
				res.selected = 1'b1;
			end else if (refused_total != TOTAL_MAX) begin
				refused_total++;
			end
		end
		OP_QUERY: begin
			if (pair_slot(node[0], node[1], slot[0]))
				res.edge_count = marks[slot[0]];
		end
		OP_CLEAR: begin
			foreach (marks[i])
				marks[i] = '0;
			taken_total = '0;
			refused_total = '0;
		end
		default: ;
		endcase
		res.selected_paths = taken_total;
		res.rejected_paths = refused_total;
		return res;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			foreach (marks[i])
				marks[i] = '0;
			taken_total = '0;
			refused_total = '0;
			expected_outcomes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			// The result is registered, so a result leaving at this edge always belongs
			// to an earlier item than one entering at it.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got 0x%h", $time,
						m_axis_tdata);
				end else begin
					want = expected_outcomes.pop_front();
					check_field("selected", want.selected, m_axis_tdata[0]);
					check_field("edge_count", want.edge_count, m_axis_tdata[8:1]);
					check_field("selected_paths", want.selected_paths, m_axis_tdata[28:9]);
					check_field("rejected_paths", want.rejected_paths, m_axis_tdata[48:29]);
					check_field("padding", 0, m_axis_tdata[OUT_DATA_W-1:49]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_outcomes.push_back(apply_probe_item(s_axis_tuser, s_axis_tdata));
			fail_count <= mismatches;
			pending_count <= expected_outcomes.size();
		end
	end

endmodule

/* test/testbench.sv */
// Top of the probe path selector testbench: clock, reset, item stimulus and
// receiver stalls, with path_selector_checker beside the block to judge results.
// Depends on epdps_pkg, the block and path_selector_checker.
`timescale 1ns / 100ps

module testbench;
	import epdps_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = OP_OFFER;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	int                    fail_count;
	int                    pending_count;

	int                    send_idle_pct = 9;
	int                    recv_idle_pct = 59;
	logic [NODE_W-1:0]     window_base = '0;
	logic [NODE_W-1:0]     last_a = '0;
	logic [NODE_W-1:0]     last_b = '0;

	edge_disjoint_probe_path_selector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	path_selector_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Most nodes come from a narrow window so that paths collide and get refused.
	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(99) < 65)
			return window_base + NODE_W'($urandom_range(7));
		return NODE_W'($urandom_range(63));
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] nf,
		input logic [NODE_W-1:0] ns, input logic [NODE_W-1:0] nt, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, len, nt, ns, nf};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Holds the sender off until every result in flight has been received.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	initial begin
		#(12 * 1_000_000);
		$display("edge_disjoint_probe_path_selector verification failed");
		$finish;
	end

	initial begin
		logic [OP_W-1:0]   op;
		logic [NODE_W-1:0] na;
		logic [NODE_W-1:0] nb;
		logic [NODE_W-1:0] nc;
		logic [LEN_W-1:0]  len;
		int unsigned       pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty store, single nodes, self loops, repeated pairs,
		// refusal on a later edge, the unused op and a clear.
		send_item(OP_QUERY, 6'd0, 6'd0, 6'd0, 2'd2);
		send_item(OP_OFFER, 6'd63, 6'd0, 6'd0, 2'd1);
		send_item(OP_OFFER, 6'd5, 6'd17, 6'd33, 2'd0);
		send_item(OP_OFFER, 6'd0, 6'd63, 6'd0, 2'd2);
		send_item(OP_QUERY, 6'd63, 6'd0, 6'd0, 2'd0);
		send_item(OP_OFFER, 6'd63, 6'd0, 6'd0, 2'd2);
		send_item(OP_OFFER, 6'd7, 6'd7, 6'd0, 2'd2);
		send_item(OP_QUERY, 6'd7, 6'd7, 6'd0, 2'd3);
		send_item(OP_OFFER, 6'd10, 6'd20, 6'd10, 2'd3);
		send_item(OP_QUERY, 6'd20, 6'd10, 6'd0, 2'd1);
		send_item(OP_OFFER, 6'd50, 6'd0, 6'd63, 2'd3);
		send_item(OP_QUERY, 6'd0, 6'd50, 6'd0, 2'd1);
		send_item(OP_OFFER, 6'd9, 6'd9, 6'd9, 2'd3);
		send_item(OP_QUERY, 6'd9, 6'd9, 6'd9, 2'd2);
		send_item(OP_UNUSED, 6'd63, 6'd63, 6'd63, 2'd3);
		send_item(OP_OFFER, 6'd63, 6'd62, 6'd61, 2'd3);
		send_item(OP_OFFER, 6'd40, 6'd41, 6'd63, 2'd2);
		send_item(OP_QUERY, 6'd41, 6'd63, 6'd0, 2'd0);
		send_item(OP_CLEAR, 6'd63, 6'd63, 6'd63, 2'd3);
		send_item(OP_QUERY, 6'd0, 6'd63, 6'd0, 2'd0);
		send_item(OP_OFFER, 6'd0, 6'd63, 6'd7, 2'd3);
		send_item(OP_QUERY, 6'd7, 6'd63, 6'd0, 2'd0);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 9;
				recv_idle_pct = 59;
			end
			1: begin
				send_idle_pct = 59;
				recv_idle_pct = 9;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			for (int n = 0; n < 410; n++) begin
				pick = $urandom_range(999);
				na = pick_node();
				nb = pick_node();
				nc = pick_node();
				len = LEN_W'($urandom_range(3));
				if ($urandom_range(99) < 80)
					len = ($urandom_range(99) < 60) ? 2'd3 : 2'd2;
				if (pick < 8) begin
					op = OP_CLEAR;
					window_base = NODE_W'($urandom_range(63));
				end else if (pick < 35) begin
					op = OP_UNUSED;
				end else if (pick < 240) begin
					op = OP_QUERY;
					if ($urandom_range(1)) begin
						na = $urandom_range(1) ? last_a : last_b;
						nb = (na == last_a) ? last_b : last_a;
					end
				end else begin
					op = OP_OFFER;
					last_a = na;
					last_b = nb;
				end
				send_item(op, na, nb, nc, len);
			end
			drain_results();
		end

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("edge_disjoint_probe_path_selector verification clean");
		else
			$display("edge_disjoint_probe_path_selector verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/epdps_pkg.sv
hw/rtl/epdps_ram.sv
hw/rtl/epdps_pair.sv
hw/rtl/edge_disjoint_probe_path_selector.sv
test/path_selector_checker.sv
test/testbench.sv
